### src/jhmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 header marker parser package
// Shared types, phase codes, marker codes and status codes.
// ----------------------------------------------------------------------------
package jhmp_pkg;

   localparam int InByteWidth     = 8;
   localparam int FieldIdWidth    = 6;
   localparam int EntryIndexWidth = 16;
   localparam int FieldValueWidth = 32;
   localparam int StatusWidth     = 4;
   localparam int PhaseWidth      = 6;

   // Parse phases. Field phases equal the field identifier they produce.
   localparam logic [PhaseWidth-1:0] PH_LSIZ     = 6'd1;
   localparam logic [PhaseWidth-1:0] PH_RSIZ     = 6'd2;
   localparam logic [PhaseWidth-1:0] PH_XSIZ     = 6'd3;
   localparam logic [PhaseWidth-1:0] PH_YTOSIZ   = 6'd10;
   localparam logic [PhaseWidth-1:0] PH_CSIZ     = 6'd11;
   localparam logic [PhaseWidth-1:0] PH_SSIZ     = 6'd12;
   localparam logic [PhaseWidth-1:0] PH_XRSIZ    = 6'd13;
   localparam logic [PhaseWidth-1:0] PH_YRSIZ    = 6'd14;
   localparam logic [PhaseWidth-1:0] PH_LQCD     = 6'd15;
   localparam logic [PhaseWidth-1:0] PH_SQCD     = 6'd16;
   localparam logic [PhaseWidth-1:0] PH_SPQCD    = 6'd17;
   localparam logic [PhaseWidth-1:0] PH_LQCC     = 6'd18;
   localparam logic [PhaseWidth-1:0] PH_CQCC     = 6'd19;
   localparam logic [PhaseWidth-1:0] PH_SQCC     = 6'd20;
   localparam logic [PhaseWidth-1:0] PH_SPQCC    = 6'd21;
   localparam logic [PhaseWidth-1:0] PH_LCOD     = 6'd22;
   localparam logic [PhaseWidth-1:0] PH_SGCOD_A  = 6'd24;
   localparam logic [PhaseWidth-1:0] PH_SGCOD_B  = 6'd25;
   localparam logic [PhaseWidth-1:0] PH_SGCOD_C  = 6'd26;
   localparam logic [PhaseWidth-1:0] PH_SPCOD_E  = 6'd28;
   localparam logic [PhaseWidth-1:0] PH_SPCOD_F  = 6'd29;
   localparam logic [PhaseWidth-1:0] PH_SPCOD_H  = 6'd31;
   localparam logic [PhaseWidth-1:0] PH_SPCOD_I  = 6'd32;
   localparam logic [PhaseWidth-1:0] PH_SOC      = 6'd33;
   localparam logic [PhaseWidth-1:0] PH_SIZ      = 6'd34;
   localparam logic [PhaseWidth-1:0] PH_MARK     = 6'd35;

   localparam logic [15:0] MK_SOC = 16'hff4f;
   localparam logic [15:0] MK_SIZ = 16'hff51;
   localparam logic [15:0] MK_QCD = 16'hff5c;
   localparam logic [15:0] MK_QCC = 16'hff5d;
   localparam logic [15:0] MK_COD = 16'hff52;
   localparam logic [15:0] MK_EOC = 16'hffd9;

   localparam logic [15:0] CQCC_WIDE_LIMIT = 16'd257;
   localparam logic [15:0] COD_FIXED_LEN   = 16'd12;
   localparam logic [15:0] QCD_FIXED_LEN   = 16'd3;
   localparam logic [15:0] QCC_FIXED_NARROW = 16'd4;
   localparam logic [15:0] QCC_FIXED_WIDE   = 16'd5;

   localparam logic [StatusWidth-1:0] ST_FIELD       = 4'd0;
   localparam logic [StatusWidth-1:0] ST_EOC         = 4'd1;
   localparam logic [StatusWidth-1:0] ST_NO_SOC      = 4'd2;
   localparam logic [StatusWidth-1:0] ST_NO_SIZ      = 4'd3;
   localparam logic [StatusWidth-1:0] ST_REPEAT_SIZ  = 4'd4;
   localparam logic [StatusWidth-1:0] ST_UNKNOWN_MK  = 4'd5;
   localparam logic [StatusWidth-1:0] ST_BAD_SQ      = 4'd6;
   localparam logic [StatusWidth-1:0] ST_BAD_ORDER   = 4'd7;
   localparam logic [StatusWidth-1:0] ST_BAD_XFORM   = 4'd8;
   localparam logic [StatusWidth-1:0] ST_BAD_CBLK    = 4'd9;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [1:0]            byte_count;
      logic [31:0]           accum;
      logic [15:0]           seg_len;
      logic [15:0]           entries_left;
      logic [15:0]           entry_counter;
      logic [15:0]           comp_count;
      logic                  two_byte;
      logic                  halted;
   } jhmp_state_type;

   typedef struct packed {
      logic [FieldIdWidth-1:0]    field_id;
      logic [EntryIndexWidth-1:0] entry_index;
      logic [FieldValueWidth-1:0] field_value;
      logic [StatusWidth-1:0]     status;
   } jhmp_rsp_type;

endpackage

### src/jhmp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 header marker parser channels
// Valid/ready channels for codestream bytes and parsed field words.
// ----------------------------------------------------------------------------
interface jhmp_req_if;
   logic                              valid;
   logic                              ready;
   logic [jhmp_pkg::InByteWidth-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface jhmp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [jhmp_pkg::FieldIdWidth-1:0]     field_id;
   logic [jhmp_pkg::EntryIndexWidth-1:0]  entry_index;
   logic [jhmp_pkg::FieldValueWidth-1:0]  field_value;
   logic [jhmp_pkg::StatusWidth-1:0]      status;

   modport source (output valid, output field_id, output entry_index,
                   output field_value, output status, input ready);
   modport sink   (input valid, input field_id, input entry_index,
                   input field_value, input status, output ready);
endinterface

### src/jhmp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 header marker parser step
// Next parser state and the optional field word for one codestream byte.
// ----------------------------------------------------------------------------
module jhmp_step (
   input  jhmp_pkg::jhmp_state_type               cur,
   input  logic [jhmp_pkg::InByteWidth-1:0]       in_byte,
   output jhmp_pkg::jhmp_state_type               nxt,
   output logic                                   emit,
   output jhmp_pkg::jhmp_rsp_type                 rsp
);

   logic [31:0]                       acc;
   logic [1:0]                        cnt;
   logic [1:0]                        need;
   logic                              two_new;
   logic                              comp_narrow;
   logic [15:0]                       fixed_len;
   logic [15:0]                       n_sub;
   logic [15:0]                       n_quant;
   logic [15:0]                       n_cod;
   logic [jhmp_pkg::PhaseWidth-1:0]   phase_nxt;

   always_comb begin
      acc         = {cur.accum[23:0], in_byte};
      cnt         = cur.byte_count + 2'd1;
      comp_narrow = cur.comp_count < jhmp_pkg::CQCC_WIDE_LIMIT;
      two_new     = acc[4:0] != 5'd0;

      unique case (cur.phase) inside
         [jhmp_pkg::PH_XSIZ:jhmp_pkg::PH_YTOSIZ]: need = 2'd0;
         jhmp_pkg::PH_LSIZ, jhmp_pkg::PH_RSIZ, jhmp_pkg::PH_CSIZ,
         jhmp_pkg::PH_LQCD, jhmp_pkg::PH_LQCC, jhmp_pkg::PH_LCOD,
         jhmp_pkg::PH_SGCOD_B, jhmp_pkg::PH_SOC, jhmp_pkg::PH_SIZ,
         jhmp_pkg::PH_MARK: need = 2'd2;
         jhmp_pkg::PH_SPQCD, jhmp_pkg::PH_SPQCC: need = cur.two_byte ? 2'd2 : 2'd1;
         jhmp_pkg::PH_CQCC: need = comp_narrow ? 2'd1 : 2'd2;
         default: need = 2'd1;
      endcase

      if (cur.phase == jhmp_pkg::PH_SQCD) begin
         fixed_len = jhmp_pkg::QCD_FIXED_LEN;
      end else if (comp_narrow) begin
         fixed_len = jhmp_pkg::QCC_FIXED_NARROW;
      end else begin
         fixed_len = jhmp_pkg::QCC_FIXED_WIDE;
      end
      n_sub   = (cur.seg_len >= fixed_len) ? cur.seg_len - fixed_len : 16'd0;
      n_quant = two_new ? (n_sub >> 1) : n_sub;
      n_cod   = (cur.seg_len >= jhmp_pkg::COD_FIXED_LEN) ?
                cur.seg_len - jhmp_pkg::COD_FIXED_LEN : 16'd0;

      nxt       = cur;
      emit      = 1'b0;
      rsp       = '0;
      phase_nxt = cur.phase + 6'd1;

      if (cnt != need) begin
         nxt.accum      = acc;
         nxt.byte_count = cnt;
      end else begin
         nxt.accum       = '0;
         nxt.byte_count  = 2'd0;
         emit            = 1'b1;
         rsp.field_id    = cur.phase;
         rsp.field_value = acc;
         rsp.status      = jhmp_pkg::ST_FIELD;

         unique case (cur.phase) inside
            jhmp_pkg::PH_SOC, jhmp_pkg::PH_SIZ, jhmp_pkg::PH_MARK: begin
               rsp.field_id    = '0;
               rsp.field_value = {16'd0, acc[15:0]};
               if (cur.phase == jhmp_pkg::PH_SOC) begin
                  if (acc[15:0] != jhmp_pkg::MK_SOC) rsp.status = jhmp_pkg::ST_NO_SOC;
                  else phase_nxt = jhmp_pkg::PH_SIZ;
               end else if (cur.phase == jhmp_pkg::PH_SIZ) begin
                  if (acc[15:0] != jhmp_pkg::MK_SIZ) rsp.status = jhmp_pkg::ST_NO_SIZ;
                  else phase_nxt = jhmp_pkg::PH_LSIZ;
               end else if (acc[15:0] == jhmp_pkg::MK_SIZ) begin
                  rsp.status = jhmp_pkg::ST_REPEAT_SIZ;
               end else if (acc[15:0] == jhmp_pkg::MK_EOC) begin
                  rsp.status = jhmp_pkg::ST_EOC;
               end else if (acc[15:0] == jhmp_pkg::MK_QCD) begin
                  phase_nxt = jhmp_pkg::PH_LQCD;
               end else if (acc[15:0] == jhmp_pkg::MK_QCC) begin
                  phase_nxt = jhmp_pkg::PH_LQCC;
               end else if (acc[15:0] == jhmp_pkg::MK_COD) begin
                  phase_nxt = jhmp_pkg::PH_LCOD;
               end else begin
                  rsp.status = jhmp_pkg::ST_UNKNOWN_MK;
               end
            end
            jhmp_pkg::PH_CSIZ: begin
               nxt.comp_count    = acc[15:0];
               nxt.entries_left  = acc[15:0];
               nxt.entry_counter = '0;
               phase_nxt = (acc[15:0] == 16'd0) ? jhmp_pkg::PH_MARK : jhmp_pkg::PH_SSIZ;
            end
            jhmp_pkg::PH_SSIZ, jhmp_pkg::PH_XRSIZ: begin
               rsp.entry_index = cur.entry_counter;
            end
            jhmp_pkg::PH_YRSIZ, jhmp_pkg::PH_SPQCD, jhmp_pkg::PH_SPQCC,
            jhmp_pkg::PH_SPCOD_I: begin
               rsp.entry_index   = cur.entry_counter;
               nxt.entry_counter = cur.entry_counter + 16'd1;
               nxt.entries_left  = cur.entries_left - 16'd1;
               if (cur.entries_left == 16'd1) begin
                  phase_nxt = jhmp_pkg::PH_MARK;
               end else if (cur.phase == jhmp_pkg::PH_YRSIZ) begin
                  phase_nxt = jhmp_pkg::PH_SSIZ;
               end else begin
                  phase_nxt = cur.phase;
               end
            end
            jhmp_pkg::PH_LQCD, jhmp_pkg::PH_LQCC, jhmp_pkg::PH_LCOD: begin
               nxt.seg_len = acc[15:0];
            end
            jhmp_pkg::PH_SQCD, jhmp_pkg::PH_SQCC: begin
               if (acc[4:0] > 5'd2) begin
                  rsp.status = jhmp_pkg::ST_BAD_SQ;
               end else begin
                  nxt.two_byte      = two_new;
                  nxt.entries_left  = n_quant;
                  nxt.entry_counter = '0;
                  if (n_quant == 16'd0) phase_nxt = jhmp_pkg::PH_MARK;
               end
            end
            jhmp_pkg::PH_SGCOD_A: begin
               if (acc > 32'd4) rsp.status = jhmp_pkg::ST_BAD_ORDER;
            end
            jhmp_pkg::PH_SGCOD_C: begin
               if (acc > 32'd1) rsp.status = jhmp_pkg::ST_BAD_XFORM;
            end
            jhmp_pkg::PH_SPCOD_E, jhmp_pkg::PH_SPCOD_F: begin
               if (acc[3:0] > 4'd8) rsp.status = jhmp_pkg::ST_BAD_CBLK;
            end
            jhmp_pkg::PH_SPCOD_H: begin
               nxt.entries_left  = n_cod;
               nxt.entry_counter = '0;
               if (n_cod == 16'd0) phase_nxt = jhmp_pkg::PH_MARK;
            end
            default: begin
            end
         endcase

         if (rsp.status != jhmp_pkg::ST_FIELD) begin
            nxt.halted = 1'b1;
         end else begin
            nxt.phase = phase_nxt;
         end
      end
   end

endmodule

### src/jpeg2000_header_marker_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 header marker parser core
// Parses SOC, SIZ, QCD, QCC, COD and EOC from a codestream byte stream.
// ----------------------------------------------------------------------------
// The core takes one codestream byte per clock while ready is high and
// finishes all work on it in the cycle it is accepted, so a new byte can
// enter every such cycle. Each byte that completes a marker or a segment field
// loads the output register with one field word; ready drops only while that
// register holds a word that the sink has not taken. After EOC or any error
// word, further bytes are still accepted but discarded until reset.
module jpeg2000_header_marker_parser_core (
   input  logic           clock,
   input  logic           reset,
   jhmp_req_if.sink       req_if,
   jhmp_rsp_if.source     rsp_if
);

   jhmp_pkg::jhmp_state_type  state_ff, state_in, step_nxt;
   jhmp_pkg::jhmp_rsp_type    rsp_ff, rsp_in, step_rsp;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      step_emit;
   logic                      accept;
   logic                      produce;

   jhmp_step u_step (
      .cur     (state_ff),
      .in_byte (req_if.in_byte),
      .nxt     (step_nxt),
      .emit    (step_emit),
      .rsp     (step_rsp)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign produce      = accept && !state_ff.halted && step_emit;

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) rsp_valid_in = 1'b0;
      if (accept && !state_ff.halted) state_in = step_nxt;
      if (produce) begin
         rsp_in       = step_rsp;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= {jhmp_pkg::PH_SOC,
                          {($bits(jhmp_pkg::jhmp_state_type) - jhmp_pkg::PhaseWidth){1'b0}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.field_id    = rsp_ff.field_id;
   assign rsp_if.entry_index = rsp_ff.entry_index;
   assign rsp_if.field_value = rsp_ff.field_value;
   assign rsp_if.status      = rsp_ff.status;

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff.halted |=> state_ff.halted)
      else $error("parser left the halted state");

   a_error_halts : assert property (@(posedge clock) disable iff (reset)
      (produce && step_rsp.status != jhmp_pkg::ST_FIELD) |=> state_ff.halted)
      else $error("error or EOC word did not halt the parser");

   a_no_word_when_halted : assert property (@(posedge clock) disable iff (reset)
      (state_ff.halted && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("word produced while halted");

   a_emit_clears_count : assert property (@(posedge clock) disable iff (reset)
      produce |=> (state_ff.byte_count == 2'd0 && state_ff.accum == 32'd0))
      else $error("byte assembly not cleared after a field word");

   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != 6'd0 && state_ff.phase <= jhmp_pkg::PH_MARK))
      else $error("parse phase out of range");

endmodule
